// ===== design/pffc_pkg.sv =====
`timescale 1ns / 1ps

package pffc_pkg;

   localparam int DATA_FRAC_BITS = 8;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int SMOOTH_SHIFT   = 12;
   localparam int SMOOTH_ONE     = 4096;

   localparam int SPEED_W = 24;
   localparam int ERR_W   = SPEED_W + 1;
   localparam int GAIN_W  = 16;
   localparam int COEF_W  = 13;
   localparam int DRIVE_W = 15;
   localparam int STATE_W = 32;
   localparam int IDX_W   = 2;
   localparam int CSR_W   = 16;

   localparam int ONE        = 1 << DATA_FRAC_BITS;
   localparam int INTEG_LIM  = 25 * ONE;
   localparam int INTEG_W    = $clog2(INTEG_LIM + 1) + 1;
   localparam int DECAY_DIV  = 100;
   localparam int DEAD_LIM   = (15 * ONE + DECAY_DIV - 1) / DECAY_DIV;
   localparam int SMALL_LIM  = (3 * ONE + DECAY_DIV - 1) / DECAY_DIV;
   localparam int DEAD_W     = $clog2(DEAD_LIM);
   localparam int NUM_SMALL  = 96 * ONE;
   localparam int NUM_BASE   = 95 * ONE;
   localparam int NUM_W      = $clog2(NUM_SMALL + 1);
   localparam int Y_W        = $clog2(25 * 96 * ONE + 1);
   localparam int DRIVE_MAX  = 100 * ONE;

   // floor(y / 100) = (y * RECIP_MUL) >> RECIP_SHIFT, then a one-step fixup
   localparam int    RECIP_SHIFT = Y_W + 7;
   localparam int    RECIP_W     = RECIP_SHIFT - 6;
   localparam longint RECIP_MUL  =
      ((64'sd1 <<< RECIP_SHIFT) + DECAY_DIV - 1) / DECAY_DIV;

   localparam int MUL_A_W = STATE_W + 1;
   localparam int MUL_B_W = RECIP_W + 1;
   localparam int ACC_W   = MUL_A_W + MUL_B_W;

   localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 16'd8806;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 16'd983;
   localparam logic [GAIN_W-1:0] FF_GAIN_RST     = 16'd3195;
   localparam logic [COEF_W-1:0] SMOOTH_COEF_RST = 13'd2540;

   typedef enum logic [IDX_W-1:0] {
      CSR_PROP_GAIN   = 2'd0,
      CSR_INTEG_GAIN  = 2'd1,
      CSR_FF_GAIN     = 2'd2,
      CSR_SMOOTH_COEF = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      MAC_NONE,
      MAC_LOAD,
      MAC_ADD
   } mac_op_type;

   typedef enum logic [2:0] {
      SEL_FF,
      SEL_PROP,
      SEL_INTEG,
      SEL_DECAY,
      SEL_RECIP,
      SEL_CHECK,
      SEL_HIST,
      SEL_NEW
   } opnd_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INTEG,
      ST_PROP,
      ST_INTG,
      ST_DRAIN,
      ST_RAW,
      ST_DEC_W1,
      ST_DEC_Y,
      ST_DEC_W2,
      ST_DEC_Q,
      ST_DEC_W3,
      ST_DEC_FIX,
      ST_FILT_A,
      ST_FILT_B,
      ST_FILT_W,
      ST_FILT_D,
      ST_OUT
   } fsm_type;

   typedef struct packed {
      logic         in_ready;
      mac_op_type   op;
      opnd_sel_type sel;
      logic         ld_integ;
      logic         ld_raw;
      logic         ld_y;
      logic         ld_q;
      logic         ld_fix;
      logic         ld_state;
      logic         ld_out;
   } ctl_type;

   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [ACC_W-1:0]   hi;
      logic signed [ACC_W-1:0]   lo;
      logic signed [STATE_W-1:0] res;
      hi = {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         res = hi[STATE_W-1:0];
      end else if (v < lo) begin
         res = lo[STATE_W-1:0];
      end else begin
         res = v[STATE_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== design/pffc_mac.sv =====
`timescale 1ns / 1ps

module pffc_mac import pffc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  mac_op_type                op,
   input  logic signed [MUL_A_W-1:0] opnd_a,
   input  logic signed [MUL_B_W-1:0] opnd_b,
   output logic signed [ACC_W-1:0]   acc
);

   mac_op_type               op_ff;
   logic signed [ACC_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod_in = opnd_a * opnd_b;

   always_comb begin
      case (op_ff)
         MAC_LOAD: acc_in = prod_ff;
         MAC_ADD:  acc_in = acc_ff + prod_ff;
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= MAC_NONE;
      end else begin
         op_ff <= op;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== design/pffc_ctrl.sv =====
`timescale 1ns / 1ps

module pffc_ctrl import pffc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    dead,
   input  logic    slot_free,
   output ctl_type ctl
);

   fsm_type state_ff;
   fsm_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (start) state_in = ST_INTEG;
         ST_INTEG:   state_in = ST_PROP;
         ST_PROP:    state_in = ST_INTG;
         ST_INTG:    state_in = ST_DRAIN;
         ST_DRAIN:   state_in = ST_RAW;
         ST_RAW:     state_in = dead ? ST_DEC_W1 : ST_FILT_A;
         ST_DEC_W1:  state_in = ST_DEC_Y;
         ST_DEC_Y:   state_in = ST_DEC_W2;
         ST_DEC_W2:  state_in = ST_DEC_Q;
         ST_DEC_Q:   state_in = ST_DEC_W3;
         ST_DEC_W3:  state_in = ST_DEC_FIX;
         ST_DEC_FIX: state_in = ST_FILT_A;
         ST_FILT_A:  state_in = ST_FILT_B;
         ST_FILT_B:  state_in = ST_FILT_W;
         ST_FILT_W:  state_in = ST_FILT_D;
         ST_FILT_D:  state_in = ST_OUT;
         ST_OUT:     if (slot_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      ctl.op  = MAC_NONE;
      ctl.sel = SEL_FF;
      unique case (state_ff)
         ST_IDLE: ctl.in_ready = 1'b1;
         ST_INTEG: begin
            ctl.ld_integ = 1'b1;
            ctl.op       = MAC_LOAD;
            ctl.sel      = SEL_FF;
         end
         ST_PROP: begin
            ctl.op  = dead ? MAC_NONE : MAC_ADD;
            ctl.sel = SEL_PROP;
         end
         ST_INTG: begin
            ctl.op  = dead ? MAC_NONE : MAC_ADD;
            ctl.sel = SEL_INTEG;
         end
         ST_RAW: begin
            ctl.ld_raw = 1'b1;
            ctl.op     = dead ? MAC_LOAD : MAC_NONE;
            ctl.sel    = SEL_DECAY;
         end
         ST_DEC_Y: begin
            ctl.ld_y = 1'b1;
            ctl.op   = MAC_LOAD;
            ctl.sel  = SEL_RECIP;
         end
         ST_DEC_Q: begin
            ctl.ld_q = 1'b1;
            ctl.op   = MAC_LOAD;
            ctl.sel  = SEL_CHECK;
         end
         ST_DEC_FIX: ctl.ld_fix = 1'b1;
         ST_FILT_A: begin
            ctl.op  = MAC_LOAD;
            ctl.sel = SEL_HIST;
         end
         ST_FILT_B: begin
            ctl.op  = MAC_ADD;
            ctl.sel = SEL_NEW;
         end
         ST_FILT_D: ctl.ld_state = 1'b1;
         ST_OUT:    ctl.ld_out = slot_free;
         default:   ctl.in_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/pi_feedforward_speed_controller_unit.sv =====
`timescale 1ns / 1ps

// Result registered in ST_OUT once the output slot is free; inside the deadband the
// integral decay runs first. A new item is taken only in ST_IDLE; all products go
// through one shared multiplier with a registered product and accumulator.
// Reset (synchronous): integral and filter state cleared, gains and filter
// coefficient return to defaults, no result pending.

module pi_feedforward_speed_controller_unit import pffc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,   // [23:0] measured_speed, [47:24] setpoint_speed
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [14:0] drive_level
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam logic signed [ERR_W:0] LIM_HI = (ERR_W+1)'(INTEG_LIM);
   localparam logic signed [ERR_W:0] LIM_LO = -LIM_HI;

   ctl_type ctl;

   logic [GAIN_W-1:0] prop_gain_ff;
   logic [GAIN_W-1:0] integ_gain_ff;
   logic [GAIN_W-1:0] ff_gain_ff;
   logic [COEF_W-1:0] smooth_coef_ff;

   logic signed [SPEED_W-1:0] req_meas;
   logic signed [SPEED_W-1:0] req_targ;
   logic signed [SPEED_W-1:0] targ_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [ERR_W-1:0]   err_in;

   logic signed [INTEG_W-1:0] integ_acc_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [ERR_W:0]     integ_sum;
   logic signed [INTEG_W-1:0] integ_clamp;
   logic [ERR_W-1:0]          err_mag;
   logic                      dead_ff;
   logic                      dead_in;
   logic [NUM_W-1:0]          num_ff;
   logic [NUM_W-1:0]          num_in;

   logic [INTEG_W-2:0]        integ_mag;
   logic [Y_W-1:0]            y_ff;
   logic [Y_W-1:0]            y_in;
   logic [INTEG_W-2:0]        q_ff;
   logic [INTEG_W-2:0]        q_in;
   logic [Y_W-1:0]            rem;
   logic [INTEG_W-2:0]        q_fix;

   logic signed [STATE_W-1:0] raw_ff;
   logic signed [STATE_W-1:0] smoothed_ff;
   logic [COEF_W-1:0]         coef_eff;
   logic [COEF_W-1:0]         coef_rest;

   logic                      rsp_valid_ff;
   logic [DRIVE_W-1:0]        rsp_data_ff;
   logic [DRIVE_W-1:0]        drive_in;
   logic                      slot_free;
   logic                      req_fire;

   logic signed [MUL_A_W-1:0] opnd_a;
   logic signed [MUL_B_W-1:0] opnd_b;
   logic signed [ACC_W-1:0]   acc;

   pffc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid),
      .dead      (dead_ff),
      .slot_free (slot_free),
      .ctl       (ctl)
   );

   pffc_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .op     (ctl.op),
      .opnd_a (opnd_a),
      .opnd_b (opnd_b),
      .acc    (acc)
   );

   assign req_tready = ctl.in_ready;
   assign req_fire   = req_tvalid & ctl.in_ready;
   assign csr_ready  = 1'b1;
   assign slot_free  = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   assign req_meas = req_tdata[SPEED_W-1:0];
   assign req_targ = req_tdata[2*SPEED_W-1:SPEED_W];
   assign err_in   = ERR_W'(req_targ) - ERR_W'(req_meas);

   // integral update, deadband decision
   assign integ_sum = (ERR_W+1)'(integ_acc_ff) + (ERR_W+1)'(err_ff);
   always_comb begin
      if (integ_sum > LIM_HI) begin
         integ_clamp = LIM_HI[INTEG_W-1:0];
      end else if (integ_sum < LIM_LO) begin
         integ_clamp = LIM_LO[INTEG_W-1:0];
      end else begin
         integ_clamp = integ_sum[INTEG_W-1:0];
      end
   end

   assign err_mag = err_ff[ERR_W-1] ? ERR_W'(-err_ff) : ERR_W'(err_ff);
   assign dead_in = err_mag < ERR_W'(DEAD_LIM);
   assign num_in  = (err_mag < ERR_W'(SMALL_LIM)) ? NUM_W'(NUM_SMALL) :
                    NUM_W'(NUM_BASE) - NUM_W'(err_mag[DEAD_W-1:0]) * NUM_W'(DECAY_DIV);

   // integral decay, truncated toward zero on the magnitude
   assign integ_mag = integ_ff[INTEG_W-1] ? (INTEG_W-1)'(-integ_ff) :
                                            (INTEG_W-1)'(integ_ff);
   assign y_in  = acc[DATA_FRAC_BITS +: Y_W];
   assign q_in  = acc[RECIP_SHIFT +: INTEG_W-1];
   assign rem   = y_ff - acc[Y_W-1:0];
   assign q_fix = q_ff + (INTEG_W-1)'(rem >= Y_W'(DECAY_DIV));

   always_comb begin
      if (ctl.ld_fix) begin
         integ_in = integ_ff[INTEG_W-1] ? -INTEG_W'(q_fix) : INTEG_W'(q_fix);
      end else begin
         integ_in = integ_clamp;
      end
   end

   assign coef_eff  = (smooth_coef_ff > COEF_W'(SMOOTH_ONE)) ? COEF_W'(SMOOTH_ONE)
                                                              : smooth_coef_ff;
   assign coef_rest = COEF_W'(SMOOTH_ONE) - coef_eff;

   always_comb begin
      unique case (ctl.sel)
         SEL_FF: begin
            opnd_a = MUL_A_W'(targ_ff);
            opnd_b = MUL_B_W'(ff_gain_ff);
         end
         SEL_PROP: begin
            opnd_a = MUL_A_W'(err_ff);
            opnd_b = MUL_B_W'(prop_gain_ff);
         end
         SEL_INTEG: begin
            opnd_a = MUL_A_W'(integ_ff);
            opnd_b = MUL_B_W'(integ_gain_ff);
         end
         SEL_DECAY: begin
            opnd_a = MUL_A_W'(integ_mag);
            opnd_b = MUL_B_W'(num_ff);
         end
         SEL_RECIP: begin
            opnd_a = MUL_A_W'(y_in);
            opnd_b = MUL_B_W'(RECIP_MUL);
         end
         SEL_CHECK: begin
            opnd_a = MUL_A_W'(q_in);
            opnd_b = MUL_B_W'(DECAY_DIV);
         end
         SEL_HIST: begin
            opnd_a = MUL_A_W'(smoothed_ff);
            opnd_b = MUL_B_W'(coef_eff);
         end
         SEL_NEW: begin
            opnd_a = MUL_A_W'(raw_ff);
            opnd_b = MUL_B_W'(coef_rest);
         end
         default: begin
            opnd_a = '0;
            opnd_b = '0;
         end
      endcase
   end

   always_comb begin
      if (smoothed_ff[STATE_W-1]) begin
         drive_in = '0;
      end else if (smoothed_ff > STATE_W'(DRIVE_MAX)) begin
         drive_in = DRIVE_W'(DRIVE_MAX);
      end else begin
         drive_in = smoothed_ff[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff   <= PROP_GAIN_RST;
         integ_gain_ff  <= INTEG_GAIN_RST;
         ff_gain_ff     <= FF_GAIN_RST;
         smooth_coef_ff <= SMOOTH_COEF_RST;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PROP_GAIN:   prop_gain_ff   <= csr_data;
            CSR_INTEG_GAIN:  integ_gain_ff  <= csr_data;
            CSR_FF_GAIN:     ff_gain_ff     <= csr_data;
            CSR_SMOOTH_COEF: smooth_coef_ff <= csr_data[COEF_W-1:0];
            default:         prop_gain_ff   <= prop_gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_acc_ff <= '0;
         smoothed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.ld_state) begin
            integ_acc_ff <= integ_ff;
            smoothed_ff  <= sat_state(acc >>> SMOOTH_SHIFT);
         end
         if (ctl.ld_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         targ_ff <= req_targ;
         err_ff  <= err_in;
      end
      if (ctl.ld_integ) begin
         dead_ff <= dead_in;
         num_ff  <= num_in;
      end
      if (ctl.ld_integ | ctl.ld_fix) begin
         integ_ff <= integ_in;
      end
      if (ctl.ld_raw) begin
         raw_ff <= sat_state(acc >>> GAIN_FRAC_BITS);
      end
      if (ctl.ld_y) begin
         y_ff <= y_in;
      end
      if (ctl.ld_q) begin
         q_ff <= q_in;
      end
      if (ctl.ld_out) begin
         rsp_data_ff <= drive_in;
      end
   end

endmodule
